// ----- hw/rtl/small_cpu_instruction_executor_assert.svh -----
// Assertion macros shared by the executor RTL.
`ifndef SMALL_CPU_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define SMALL_CPU_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Check cons in the same cycle as ante.
`define SCE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define SCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/sce_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sce_pkg;

   // Register file geometry
   localparam int REG_FILE_DEPTH = 256;
   localparam int RF_ADDR_W      = $clog2(REG_FILE_DEPTH);

   // Special register addresses
   localparam logic [RF_ADDR_W-1:0] FLAGS_ADDR = 8'hFC;
   localparam logic [RF_ADDR_W-1:0] PTR_ADDR   = 8'hFD;

   // Flag bits
   localparam logic [7:0] ZERO_KEEP_MASK = 8'hBF;
   localparam logic [7:0] ZERO_FLAG_MASK = 8'h40;
   localparam int         ZERO_FLAG_BIT  = 6;
   localparam logic [7:0] NIBBLE_MASK    = 8'h0F;

   // Program counter after reset
   localparam logic [15:0] START_RESET = 16'h1000;

   // Opcodes decoded by low nibble
   localparam logic [3:0] OP_LO_DJNZ   = 4'hA;
   localparam logic [3:0] OP_LO_LD_IMM = 4'hC;
   localparam logic [3:0] OP_LO_INC    = 4'hE;

   // Opcodes decoded by full byte
   localparam logic [7:0] OP_STOP = 8'h6F;
   localparam logic [7:0] OP_SRP  = 8'h31;

   // Instruction lengths
   localparam logic [1:0] LEN_ONE = 2'd1;
   localparam logic [1:0] LEN_TWO = 2'd2;

endpackage

`default_nettype wire

// ----- hw/rtl/small_cpu_instruction_executor.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Ports                                   | Direction
// ---------+-----------------------------------------+----------
// request  | req_valid, req_stall, req_opcode/operand | in
// response | rsp_valid, rsp_stall, rsp_* result       | out
// csr      | csr_write_enable, csr_write_data         | in
//
// One instruction per cycle sustained while the response is not stalled; the
// accepting edge loads the request register and reads the register file, and
// the edge that executes the instruction loads the result into the response
// register. The register file read is the limiting port.
// Synchronous reset clears the pc to 0x1000, the flags, pointer, halted bit
// and all register file valid bits (cleared entries read as zero).
// Response stall holds the response and the execute stage, which then
// stalls the request side. After STOP, requests are accepted and dropped.

`include "small_cpu_instruction_executor_assert.svh"

module small_cpu_instruction_executor (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_opcode,
   input  wire logic [7:0]  req_operand,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_next_pc,
   output logic [1:0]       rsp_bytes_used,
   output logic             rsp_halted,
   output logic             rsp_zero_flag,
   output logic             rsp_write_valid,
   output logic [7:0]       rsp_write_address,
   output logic [7:0]       rsp_write_value,
   // configuration
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   localparam int AW = sce_pkg::RF_ADDR_W;

   // Architectural state
   logic [15:0]   pc_ff, pc_in;
   logic [7:0]    ptr_ff, ptr_in;
   logic [7:0]    flags_ff, flags_in;
   logic          stopped_ff, stopped_in;
   logic [7:0]    rf_mem [sce_pkg::REG_FILE_DEPTH];
   logic [sce_pkg::REG_FILE_DEPTH-1:0] rf_valid_ff;

   // Read stage
   logic          s1_valid_ff;
   logic [7:0]    s1_opcode_ff;
   logic [7:0]    s1_operand_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [7:0]    s1_rdata_ff;
   logic          s1_rvalid_ff;
   logic          s1_fwd_ff;
   logic [7:0]    s1_fwd_val_ff;

   // Response register
   logic          rsp_valid_ff;
   logic [15:0]   rsp_next_pc_ff;
   logic [1:0]    rsp_bytes_used_ff;
   logic          rsp_halted_ff;
   logic          rsp_zero_flag_ff;
   logic          rsp_write_valid_ff;
   logic [7:0]    rsp_write_address_ff;
   logic [7:0]    rsp_write_value_ff;

   // Handshake and execute signals
   logic          req_accept;
   logic          out_adv;
   logic          ex_produce;
   logic          ex_drop;
   logic [AW-1:0] rd_addr;
   logic          fwd_in;
   logic [7:0]    ex_old;
   logic [7:0]    ex_inc;
   logic [7:0]    ex_flags_base;
   logic          ex_wv;
   logic [AW-1:0] ex_wa;
   logic [7:0]    ex_val;
   logic [1:0]    ex_len;
   logic [7:0]    ex_flags;
   logic          ex_stop;
   logic [15:0]   ex_seq_pc;
   logic [15:0]   ex_pc;

   // Pipeline flow control
   always_comb begin
      out_adv    = !rsp_valid_ff || !rsp_stall;
      ex_produce = s1_valid_ff && !stopped_ff && out_adv;
      ex_drop    = s1_valid_ff && stopped_ff;
      req_stall  = s1_valid_ff && !(ex_produce || ex_drop);
      req_accept = req_valid && !req_stall;
   end

   // Fetch the working register operand, newest value first
   always_comb begin
      if (s1_addr_ff == sce_pkg::FLAGS_ADDR) begin
         ex_old = flags_ff;
      end else if (s1_addr_ff == sce_pkg::PTR_ADDR) begin
         ex_old = ptr_ff;
      end else if (s1_fwd_ff) begin
         ex_old = s1_fwd_val_ff;
      end else if (s1_rvalid_ff) begin
         ex_old = s1_rdata_ff;
      end else begin
         ex_old = '0;
      end
   end

   // Decode and execute
   always_comb begin
      ex_inc        = ex_old + 8'd1;
      ex_flags_base = (s1_addr_ff == sce_pkg::FLAGS_ADDR) ? ex_inc : flags_ff;
      ex_wv         = 1'b0;
      ex_wa         = s1_addr_ff;
      ex_val        = '0;
      ex_len        = sce_pkg::LEN_ONE;
      ex_flags      = flags_ff;
      ex_stop       = 1'b0;
      unique case (s1_opcode_ff[3:0])
         sce_pkg::OP_LO_DJNZ: begin
            ex_len = sce_pkg::LEN_TWO;
            ex_wv  = 1'b1;
            ex_val = ex_old - 8'd1;
         end
         sce_pkg::OP_LO_LD_IMM: begin
            ex_len = sce_pkg::LEN_TWO;
            ex_wv  = 1'b1;
            ex_val = s1_operand_ff;
         end
         sce_pkg::OP_LO_INC: begin
            ex_wv    = 1'b1;
            ex_flags = (ex_flags_base & sce_pkg::ZERO_KEEP_MASK)
                     | ((ex_inc == 8'd0) ? sce_pkg::ZERO_FLAG_MASK : 8'd0);
            ex_val   = (s1_addr_ff == sce_pkg::FLAGS_ADDR) ? ex_flags : ex_inc;
         end
         default: begin
            if (s1_opcode_ff == sce_pkg::OP_STOP) begin
               ex_stop = 1'b1;
            end else if (s1_opcode_ff == sce_pkg::OP_SRP) begin
               ex_len = sce_pkg::LEN_TWO;
               ex_wv  = 1'b1;
               ex_wa  = sce_pkg::PTR_ADDR;
               ex_val = s1_operand_ff & sce_pkg::NIBBLE_MASK;
            end
         end
      endcase
      // A plain write to the flags byte replaces it
      if (ex_wv && ex_wa == sce_pkg::FLAGS_ADDR) begin
         ex_flags = ex_val;
      end
      ex_seq_pc = pc_ff + {14'd0, ex_len};
      if (s1_opcode_ff[3:0] == sce_pkg::OP_LO_DJNZ && ex_val != 8'd0) begin
         ex_pc = ex_seq_pc + {{8{s1_operand_ff[7]}}, s1_operand_ff};
      end else begin
         ex_pc = ex_seq_pc;
      end
   end

   // Next architectural state
   always_comb begin
      ptr_in     = (ex_produce && ex_wv && ex_wa == sce_pkg::PTR_ADDR) ? ex_val : ptr_ff;
      flags_in   = ex_produce ? ex_flags : flags_ff;
      stopped_in = stopped_ff || (ex_produce && ex_stop);
      if (csr_write_enable) begin
         pc_in = csr_write_data;
      end else if (ex_produce) begin
         pc_in = ex_pc;
      end else begin
         pc_in = pc_ff;
      end
      rd_addr = {ptr_in[3:0], req_opcode[7:4]};
      fwd_in  = ex_produce && ex_wv && ex_wa == rd_addr;
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= sce_pkg::START_RESET;
         ptr_ff       <= '0;
         flags_ff     <= '0;
         stopped_ff   <= 1'b0;
         rf_valid_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff      <= pc_in;
         ptr_ff     <= ptr_in;
         flags_ff   <= flags_in;
         stopped_ff <= stopped_in;
         if (ex_produce && ex_wv) begin
            rf_valid_ff[ex_wa] <= 1'b1;
         end
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (ex_produce || ex_drop) begin
            s1_valid_ff <= 1'b0;
         end
         if (ex_produce) begin
            rsp_valid_ff <= 1'b1;
         end else if (out_adv) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Register file write and registered read
   always_ff @(posedge clock) begin
      if (ex_produce && ex_wv) begin
         rf_mem[ex_wa] <= ex_val;
      end
      if (req_accept) begin
         s1_rdata_ff <= rf_mem[rd_addr];
      end
   end

   // Capture the accepted transaction
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_opcode_ff  <= req_opcode;
         s1_operand_ff <= req_operand;
         s1_addr_ff    <= rd_addr;
         s1_rvalid_ff  <= rf_valid_ff[rd_addr];
         s1_fwd_ff     <= fwd_in;
         s1_fwd_val_ff <= ex_val;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (ex_produce) begin
         rsp_next_pc_ff       <= ex_pc;
         rsp_bytes_used_ff    <= ex_len;
         rsp_halted_ff        <= stopped_in;
         rsp_zero_flag_ff     <= ex_flags[sce_pkg::ZERO_FLAG_BIT];
         rsp_write_valid_ff   <= ex_wv;
         rsp_write_address_ff <= ex_wv ? ex_wa : '0;
         rsp_write_value_ff   <= ex_wv ? ex_val : '0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_next_pc       = rsp_next_pc_ff;
   assign rsp_bytes_used    = rsp_bytes_used_ff;
   assign rsp_halted        = rsp_halted_ff;
   assign rsp_zero_flag     = rsp_zero_flag_ff;
   assign rsp_write_valid   = rsp_write_valid_ff;
   assign rsp_write_address = rsp_write_address_ff;
   assign rsp_write_value   = rsp_write_value_ff;

   // Checks
   `SCE_ASSERT_NEXT(a_stop_sticky, clock, reset, stopped_ff, stopped_ff,
      "halted bit cleared")
   `SCE_ASSERT_NOW(a_len_range, clock, reset, rsp_valid_ff,
      (rsp_bytes_used_ff == sce_pkg::LEN_ONE || rsp_bytes_used_ff == sce_pkg::LEN_TWO),
      "bad instruction length")
   `SCE_ASSERT_NOW(a_no_write_zero, clock, reset, rsp_valid_ff && !rsp_write_valid_ff,
      (rsp_write_address_ff == 8'd0 && rsp_write_value_ff == 8'd0),
      "write fields set without write")
   `SCE_ASSERT_NEXT(a_ptr_tracks, clock, reset,
      ex_produce && ex_wv && ex_wa == sce_pkg::PTR_ADDR,
      ptr_ff == rsp_write_value_ff, "pointer copy differs from written value")
   `SCE_ASSERT_NOW(a_no_result_halted, clock, reset, ex_produce, !stopped_ff,
      "result produced after STOP")

endmodule

`default_nettype wire
